// ----- rtl/core/lclm_pkg.sv -----
package lclm_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_RENUM  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_CELLS_X = 3'd0;
    localparam logic [2:0] REG_CELLS_Y = 3'd1;
    localparam logic [2:0] REG_CELLS_Z = 3'd2;
    localparam logic [2:0] REG_PAD     = 3'd3;
    localparam logic [2:0] REG_INV_X   = 3'd4;
    localparam logic [2:0] REG_INV_Y   = 3'd5;
    localparam logic [2:0] REG_INV_Z   = 3'd6;

    // one half in the Q.40 product scale
    localparam logic signed [63:0] HALF_Q40 = 64'sh0000_0080_0000_0000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_IDX,
        ST_CELL,
        ST_RD_A,
        ST_RD_B,
        ST_DECIDE,
        ST_WALK_HEAD,
        ST_CHK_HEAD,
        ST_WALK_NEXT,
        ST_CHK_NEXT,
        ST_LINK_RD,
        ST_LINK_WR,
        ST_CLR_A,
        ST_DONE
    } state_t;

    // cell count saturated into the supported range
    function automatic logic [4:0] eff_cells(input logic [4:0] n);
        if (n < 5'd3) begin
            return 5'd3;
        end else if (n > 5'd16) begin
            return 5'd16;
        end
        return n;
    endfunction

    // pad limited so that one inner cell remains
    function automatic logic [2:0] eff_pad(input logic [2:0] pad, input logic [4:0] n);
        logic [4:0] lim;
        lim = (n - 5'd1) >> 1;
        if ({2'b00, pad} > lim) begin
            return lim[2:0];
        end
        return pad;
    endfunction

endpackage

// ----- rtl/core/lclm_ram.sv -----
module lclm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/linked_cell_list_manager.sv -----
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tuser command, s_tdata indexes and position
// m_        out  m_tvalid/m_tready    m_tdata cell_now, cell_before, relinked
// cfg_      in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// update bins each position axis on the shared multiplier, forms the cell number, reads
// the old cell, walks the list entries of the old cell, then pushes and gives the result
// (the result alone when the cell is unchanged).
// remove and renumber read the old cell and walk its list, remove then clears the links;
// clear all lists adds a sweep over max(MAX_CELLS, MAX_PARTICLES) entries, which also
// runs after reset. A new item is taken only in idle; a waiting result holds the done state.
module linked_cell_list_manager #(
    parameter int MAX_PARTICLES = 4096,
    parameter int MAX_CELLS     = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // command
    input  logic [119:0] s_tdata,   // atom_index, new_index, pos_x, pos_y, pos_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // cell_now, cell_before, relinked, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int PW    = $clog2(MAX_PARTICLES);
    localparam int CW    = $clog2(MAX_CELLS);
    localparam int MAXD  = (MAX_PARTICLES > MAX_CELLS) ? MAX_PARTICLES : MAX_CELLS;
    localparam int SWW   = $clog2(MAXD);
    localparam int STW   = $clog2(MAX_PARTICLES + 1);
    localparam logic [SWW-1:0] SW_LAST   = SWW'(MAXD - 1);
    localparam logic [STW-1:0] STEP_LAST = STW'(MAX_PARTICLES);

    lclm_pkg::state_t state_reg, state_next, ret_state;

    // configuration
    logic [4:0]  cells_x_reg, cells_y_reg, cells_z_reg;
    logic [2:0]  pad_reg;
    logic [31:0] inv_x_reg, inv_y_reg, inv_z_reg;

    // control
    logic            m_tvalid_reg;
    logic [SWW-1:0]  sw_reg;
    logic [1:0]      ax_reg;
    logic            clr_cmd_reg;
    logic [STW-1:0]  steps_reg;

    // payload
    logic [1:0]      cmd_reg;
    logic [PW-1:0]   a_reg, b_reg;
    logic            a_ok_reg;
    logic [31:0]     pos_reg [3];
    logic [63:0]     prod_reg;
    logic [3:0]      idx_reg [3];
    logic [CW-1:0]   c_reg;
    logic [CW:0]     ca_reg;
    logic [PW:0]     na_reg;
    logic [CW-1:0]   rel_c_reg;
    logic [PW-1:0]   rel_from_reg;
    logic [PW:0]     rel_to_reg;
    logic [PW-1:0]   j_reg;
    logic [CW:0]     now_reg, before_reg;
    logic            changed_reg;
    logic [31:0]     m_tdata_reg;

    // ram ports
    logic            head_we, next_we, pcell_we;
    logic [CW-1:0]   head_waddr, head_raddr;
    logic [PW-1:0]   next_waddr, next_raddr, pcell_waddr, pcell_raddr;
    logic [PW:0]     head_wdata, head_rdata, next_wdata, next_rdata;
    logic [CW:0]     pcell_wdata, pcell_rdata;

    // input beat fields
    logic [1:0]  in_cmd;
    logic [11:0] in_a, in_b;
    logic        in_a_ok, in_b_ok, in_bad;

    assign in_cmd  = s_tuser;
    assign in_a    = s_tdata[11:0];
    assign in_b    = s_tdata[23:12];
    assign in_a_ok = {20'd0, in_a} < 32'(MAX_PARTICLES);
    assign in_b_ok = {20'd0, in_b} < 32'(MAX_PARTICLES);
    assign in_bad  = (in_cmd != lclm_pkg::CMD_CLEAR)
                     && (!in_a_ok || ((in_cmd == lclm_pkg::CMD_RENUM) && !in_b_ok));

    assign s_tready  = (state_reg == lclm_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // stored value to result field, empty reads as minus one
    function automatic logic [12:0] to_field(input logic [CW:0] v);
        if (v[CW]) begin
            return '1;
        end
        return 13'(v[CW-1:0]);
    endfunction

    // axis selection for the shared multiplier
    logic [31:0] inv_sel;
    logic [4:0]  n_sel;
    always_comb begin
        case (ax_reg)
            2'd0:    begin inv_sel = inv_x_reg; n_sel = lclm_pkg::eff_cells(cells_x_reg); end
            2'd1:    begin inv_sel = inv_y_reg; n_sel = lclm_pkg::eff_cells(cells_y_reg); end
            default: begin inv_sel = inv_z_reg; n_sel = lclm_pkg::eff_cells(cells_z_reg); end
        endcase
    end

    logic [63:0] mul_full;
    assign mul_full = 64'($signed(pos_reg[ax_reg]) * $signed({1'b0, inv_sel}));

    // axis index from the registered product
    logic [2:0]  p_sel;
    logic [4:0]  inner;
    logic [39:0] u_val;
    logic [44:0] uq;
    logic [3:0]  idx_val;
    always_comb begin
        p_sel = lclm_pkg::eff_pad(pad_reg, n_sel);
        inner = n_sel - {1'b0, p_sel, 1'b0};
        u_val = 40'($signed(prod_reg) + lclm_pkg::HALF_Q40);
        uq    = '0;
        for (int k = 0; k < 5; k++) begin
            if (inner[k]) begin
                uq = uq + (45'(u_val) << k);
            end
        end
        if ($signed(prod_reg) < -lclm_pkg::HALF_Q40) begin
            idx_val = {1'b0, p_sel};
        end else if ($signed(prod_reg) >= lclm_pkg::HALF_Q40) begin
            idx_val = 4'(n_sel - {2'b00, p_sel} - 5'd1);
        end else begin
            idx_val = 4'({1'b0, p_sel} + uq[43:40]);
        end
    end

    // cell number from the three axis indexes
    logic [4:0]  ny, nz;
    logic [12:0] cell_num;
    always_comb begin
        ny       = lclm_pkg::eff_cells(cells_y_reg);
        nz       = lclm_pkg::eff_cells(cells_z_reg);
        cell_num = 13'((13'(idx_reg[0]) * 13'(ny) + 13'(idx_reg[1])) * 13'(nz)
                       + 13'(idx_reg[2]));
    end

    // list walk compares
    logic head_hit, head_end, next_hit, next_end, same_cell;
    assign head_hit  = head_rdata == {1'b0, rel_from_reg};
    assign head_end  = head_hit || head_rdata[PW];
    assign next_hit  = next_rdata == {1'b0, rel_from_reg};
    assign next_end  = next_hit || next_rdata[PW];
    assign same_cell = ca_reg == {1'b0, c_reg};

    always_comb begin
        case (cmd_reg)
            lclm_pkg::CMD_UPDATE: ret_state = lclm_pkg::ST_LINK_RD;
            lclm_pkg::CMD_REMOVE: ret_state = lclm_pkg::ST_CLR_A;
            default:              ret_state = lclm_pkg::ST_DONE;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lclm_pkg::ST_CLEAR: begin
                if (sw_reg == SW_LAST) begin
                    state_next = clr_cmd_reg ? lclm_pkg::ST_DONE : lclm_pkg::ST_IDLE;
                end
            end
            lclm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_bad) begin
                        state_next = lclm_pkg::ST_DONE;
                    end else if (in_cmd == lclm_pkg::CMD_UPDATE) begin
                        state_next = lclm_pkg::ST_MUL;
                    end else begin
                        state_next = lclm_pkg::ST_RD_A;
                    end
                end
            end
            lclm_pkg::ST_MUL:  state_next = lclm_pkg::ST_IDX;
            lclm_pkg::ST_IDX: begin
                state_next = (ax_reg == 2'd2) ? lclm_pkg::ST_CELL : lclm_pkg::ST_MUL;
            end
            lclm_pkg::ST_CELL: state_next = lclm_pkg::ST_RD_A;
            lclm_pkg::ST_RD_A: state_next = lclm_pkg::ST_RD_B;
            lclm_pkg::ST_RD_B: state_next = lclm_pkg::ST_DECIDE;
            lclm_pkg::ST_DECIDE: begin
                unique case (cmd_reg)
                    lclm_pkg::CMD_CLEAR: state_next = lclm_pkg::ST_CLEAR;
                    lclm_pkg::CMD_UPDATE: begin
                        if (same_cell) begin
                            state_next = lclm_pkg::ST_DONE;
                        end else if (!ca_reg[CW]) begin
                            state_next = lclm_pkg::ST_WALK_HEAD;
                        end else begin
                            state_next = lclm_pkg::ST_LINK_RD;
                        end
                    end
                    lclm_pkg::CMD_REMOVE: begin
                        state_next = ca_reg[CW] ? lclm_pkg::ST_DONE : lclm_pkg::ST_WALK_HEAD;
                    end
                    default: begin
                        if ((a_reg == b_reg) || ca_reg[CW]) begin
                            state_next = lclm_pkg::ST_DONE;
                        end else begin
                            state_next = lclm_pkg::ST_WALK_HEAD;
                        end
                    end
                endcase
            end
            lclm_pkg::ST_WALK_HEAD: state_next = lclm_pkg::ST_CHK_HEAD;
            lclm_pkg::ST_CHK_HEAD: begin
                state_next = head_end ? ret_state : lclm_pkg::ST_WALK_NEXT;
            end
            lclm_pkg::ST_WALK_NEXT: begin
                state_next = (steps_reg == STEP_LAST) ? ret_state : lclm_pkg::ST_CHK_NEXT;
            end
            lclm_pkg::ST_CHK_NEXT: begin
                state_next = next_end ? ret_state : lclm_pkg::ST_WALK_NEXT;
            end
            lclm_pkg::ST_LINK_RD: state_next = lclm_pkg::ST_LINK_WR;
            lclm_pkg::ST_LINK_WR: state_next = lclm_pkg::ST_DONE;
            lclm_pkg::ST_CLR_A:   state_next = lclm_pkg::ST_DONE;
            lclm_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = lclm_pkg::ST_IDLE;
                end
            end
            default: state_next = lclm_pkg::ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        head_we     = 1'b0;
        next_we     = 1'b0;
        pcell_we    = 1'b0;
        head_waddr  = rel_c_reg;
        head_wdata  = rel_to_reg;
        next_waddr  = a_reg;
        next_wdata  = '1;
        pcell_waddr = a_reg;
        pcell_wdata = '1;
        head_raddr  = rel_c_reg;
        next_raddr  = a_reg;
        pcell_raddr = a_reg;
        unique case (state_reg)
            lclm_pkg::ST_CLEAR: begin
                head_we     = 32'(sw_reg) < 32'(MAX_CELLS);
                next_we     = 32'(sw_reg) < 32'(MAX_PARTICLES);
                pcell_we    = next_we;
                head_waddr  = sw_reg[CW-1:0];
                next_waddr  = sw_reg[PW-1:0];
                pcell_waddr = sw_reg[PW-1:0];
                head_wdata  = '1;
            end
            lclm_pkg::ST_RD_B: pcell_raddr = b_reg;
            lclm_pkg::ST_DECIDE: begin
                if ((cmd_reg == lclm_pkg::CMD_RENUM) && (a_reg != b_reg)) begin
                    pcell_we    = 1'b1;
                    next_we     = 1'b1;
                    pcell_waddr = b_reg;
                    next_waddr  = b_reg;
                    pcell_wdata = ca_reg;
                    next_wdata  = na_reg;
                end
            end
            lclm_pkg::ST_CHK_HEAD: head_we = head_hit;
            lclm_pkg::ST_WALK_NEXT: next_raddr = j_reg;
            lclm_pkg::ST_CHK_NEXT: begin
                next_we    = next_hit;
                next_waddr = j_reg;
                next_wdata = rel_to_reg;
            end
            lclm_pkg::ST_LINK_RD: head_raddr = c_reg;
            lclm_pkg::ST_LINK_WR: begin
                head_we     = 1'b1;
                next_we     = 1'b1;
                pcell_we    = 1'b1;
                head_waddr  = c_reg;
                head_wdata  = {1'b0, a_reg};
                next_wdata  = head_rdata;
                pcell_wdata = {1'b0, c_reg};
            end
            lclm_pkg::ST_CLR_A: begin
                next_we  = 1'b1;
                pcell_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lclm_pkg::ST_CLEAR;
            m_tvalid_reg <= 1'b0;
            sw_reg       <= '0;
            ax_reg       <= '0;
            clr_cmd_reg  <= 1'b0;
            cells_x_reg  <= 5'd16;
            cells_y_reg  <= 5'd16;
            cells_z_reg  <= 5'd16;
            pad_reg      <= 3'd1;
            inv_x_reg    <= 32'h0100_0000;
            inv_y_reg    <= 32'h0100_0000;
            inv_z_reg    <= 32'h0100_0000;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    lclm_pkg::REG_CELLS_X: cells_x_reg <= cfg_data[4:0];
                    lclm_pkg::REG_CELLS_Y: cells_y_reg <= cfg_data[4:0];
                    lclm_pkg::REG_CELLS_Z: cells_z_reg <= cfg_data[4:0];
                    lclm_pkg::REG_PAD:     pad_reg     <= cfg_data[2:0];
                    lclm_pkg::REG_INV_X:   inv_x_reg   <= cfg_data;
                    lclm_pkg::REG_INV_Y:   inv_y_reg   <= cfg_data;
                    lclm_pkg::REG_INV_Z:   inv_z_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (state_reg == lclm_pkg::ST_CLEAR) begin
                sw_reg <= sw_reg + 1'b1;
            end
            if (state_reg == lclm_pkg::ST_IDLE) begin
                ax_reg      <= '0;
                sw_reg      <= '0;
                clr_cmd_reg <= 1'b1;
            end
            if (state_reg == lclm_pkg::ST_IDX) begin
                ax_reg <= ax_reg + 2'd1;
            end
            // result beat leaves, or a new one is loaded
            if (state_reg == lclm_pkg::ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == lclm_pkg::ST_IDLE && s_tvalid) begin
            cmd_reg     <= in_cmd;
            a_reg       <= PW'(in_a);
            b_reg       <= PW'(in_b);
            a_ok_reg    <= in_a_ok;
            pos_reg[0]  <= s_tdata[55:24];
            pos_reg[1]  <= s_tdata[87:56];
            pos_reg[2]  <= s_tdata[119:88];
            now_reg     <= '1;
            before_reg  <= '1;
            changed_reg <= 1'b0;
        end
        if (state_reg == lclm_pkg::ST_MUL) begin
            prod_reg <= mul_full;
        end
        if (state_reg == lclm_pkg::ST_IDX) begin
            idx_reg[ax_reg] <= idx_val;
        end
        if (state_reg == lclm_pkg::ST_CELL) begin
            if ({19'd0, cell_num} >= 32'(MAX_CELLS)) begin
                c_reg <= CW'(MAX_CELLS - 1);
            end else begin
                c_reg <= CW'(cell_num);
            end
        end
        if (state_reg == lclm_pkg::ST_RD_B) begin
            ca_reg <= pcell_rdata;
            na_reg <= next_rdata;
        end
        if (state_reg == lclm_pkg::ST_DECIDE) begin
            rel_c_reg    <= ca_reg[CW-1:0];
            rel_from_reg <= a_reg;
            unique case (cmd_reg)
                lclm_pkg::CMD_CLEAR: begin
                    before_reg  <= a_ok_reg ? ca_reg : '1;
                    now_reg     <= '1;
                    changed_reg <= 1'b1;
                end
                lclm_pkg::CMD_UPDATE: begin
                    before_reg  <= ca_reg;
                    now_reg     <= {1'b0, c_reg};
                    changed_reg <= !same_cell;
                    rel_to_reg  <= na_reg;
                end
                lclm_pkg::CMD_REMOVE: begin
                    before_reg <= ca_reg;
                    now_reg    <= '1;
                    rel_to_reg <= na_reg;
                end
                default: begin
                    before_reg <= pcell_rdata;
                    now_reg    <= (a_reg == b_reg) ? pcell_rdata : ca_reg;
                    rel_to_reg <= {1'b0, b_reg};
                end
            endcase
        end
        // relink outcome for remove and renumber
        if (state_reg == lclm_pkg::ST_CHK_HEAD) begin
            j_reg     <= head_rdata[PW-1:0];
            steps_reg <= '0;
            if (head_end && cmd_reg != lclm_pkg::CMD_UPDATE) begin
                changed_reg <= head_hit;
            end
        end
        if (state_reg == lclm_pkg::ST_CHK_NEXT) begin
            j_reg     <= next_rdata[PW-1:0];
            steps_reg <= steps_reg + 1'b1;
            if (next_end && cmd_reg != lclm_pkg::CMD_UPDATE) begin
                changed_reg <= next_hit;
            end
        end
        if (state_reg == lclm_pkg::ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {5'd0, changed_reg, to_field(before_reg), to_field(now_reg)};
        end
    end

    lclm_ram #(.WIDTH(PW + 1), .DEPTH(MAX_CELLS)) u_head (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    lclm_ram #(.WIDTH(PW + 1), .DEPTH(MAX_PARTICLES)) u_next (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    lclm_ram #(.WIDTH(CW + 1), .DEPTH(MAX_PARTICLES)) u_pcell (
        .aclk  (aclk),
        .we    (pcell_we),
        .waddr (pcell_waddr),
        .wdata (pcell_wdata),
        .raddr (pcell_raddr),
        .rdata (pcell_rdata)
    );

endmodule
